[design/esfc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esfc_pkg
// types, constants and the coil lookup for the elevator stepper controller
// ----------------------------------------------------------------------------
package esfc_pkg;

  localparam int FLOOR_COUNT = 6;

  localparam int STEPS_W     = 14;
  localparam int FLOOR_W     = 3;
  localparam int PHASE_W     = 3;
  localparam int COUNT_W     = 16;
  localparam int COIL_W      = 4;
  localparam int LIMIT_RAW_W = FLOOR_W + STEPS_W;

  localparam logic [STEPS_W-1:0] STEPS_RESET = STEPS_W'(4096);
  localparam logic [COUNT_W-1:0] LIMIT_CAP   = COUNT_W'(65534);
  localparam logic [FLOOR_W-1:0] FLOOR_RESET = FLOOR_W'(1);
  localparam logic [FLOOR_W-1:0] CANCEL_BUTTON = FLOOR_W'(1);
  localparam logic [FLOOR_W-1:0] NO_BUTTON     = FLOOR_W'(0);

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_UP   = 2'd1,
    MODE_DOWN = 2'd2
  } travel_mode_t;

  // 8-phase half-step pattern
  function automatic logic [COIL_W-1:0] coil_lookup(input logic [PHASE_W-1:0] phase);
    logic [COIL_W-1:0] pat;
    case (phase)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'hC;
      3'd6:    pat = 4'h8;
      default: pat = 4'h9;
    endcase
    return pat;
  endfunction

endpackage
`default_nettype wire

[design/elevator_stepper_floor_controller.sv]
`timescale 1ns / 1ps
`default_nettype none
// a result item is registered in the result register, or in the skid register if that one is full and not being taken
// throughput: one tick per cycle while button_stall is low; all state updates in one short pass of logic
// a two-entry output stage (result register plus skid register) keeps input taking
// ticks while one result waits; button_stall rises only when both entries are full
// reset (rst, synchronous): idle at floor 1, phase and counter 0, coils off,
// steps_per_floor 4096, output stage empty
// ----------------------------------------------------------------------------
// elevator_stepper_floor_controller
// floor controller driving a four-coil stepper in half-step mode, one tick per item
// ----------------------------------------------------------------------------
module elevator_stepper_floor_controller (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration: steps per floor
  input  wire logic                          cfg_write,
  input  wire logic [esfc_pkg::STEPS_W-1:0]  cfg_data,
  // tick input
  input  wire logic                          button_valid,
  output logic                               button_stall,
  input  wire logic [esfc_pkg::FLOOR_W-1:0]  pressed_button,
  // coil output
  output logic                               coil_valid,
  input  wire logic                          coil_stall,
  output logic [esfc_pkg::COIL_W-1:0]        coil_pattern
);
  import esfc_pkg::*;

  // configuration register
  logic [STEPS_W-1:0] steps_per_floor;

  // controller state
  travel_mode_t       travel_mode, travel_mode_next;
  logic [FLOOR_W-1:0] current_floor, current_floor_next;
  logic [FLOOR_W-1:0] floor_distance, floor_distance_next;
  logic [PHASE_W-1:0] phase_index, phase_index_next;
  logic [COUNT_W-1:0] step_counter, step_counter_next;
  logic [COIL_W-1:0]  held_coils, held_coils_next;

  // skid entry behind the result register
  logic               skid_valid;
  logic [COIL_W-1:0]  skid_pattern;

  // handshake
  logic item_accept;
  logic out_take;

  assign button_stall = skid_valid;
  assign item_accept  = button_valid && !button_stall;
  assign out_take     = coil_valid && !coil_stall;

  // ---------------------------------------------------------------------------
  // decode of the press
  // ---------------------------------------------------------------------------
  logic button_in_range;   // a real floor button, not 0 and not above the top floor
  logic start_request;     // idle press of a floor other than the current one
  logic cancel_request;    // floor 1 pressed while moving
  logic going_up;
  logic moving;

  assign button_in_range = (pressed_button != NO_BUTTON) &&
                           ({1'b0, pressed_button} <= (FLOOR_W + 1)'(FLOOR_COUNT));
  assign start_request   = button_in_range && (pressed_button != current_floor);
  assign cancel_request  = (pressed_button == CANCEL_BUTTON);
  assign going_up        = (pressed_button > current_floor);
  assign moving          = (travel_mode == MODE_UP) || (travel_mode == MODE_DOWN);

  // ---------------------------------------------------------------------------
  // step limit: distance times steps per floor, saturated so the counter never wraps
  // ---------------------------------------------------------------------------
  logic [LIMIT_RAW_W-1:0] limit_raw;
  logic [COUNT_W-1:0]     stop_count;
  logic                   steps_left;

  assign limit_raw  = LIMIT_RAW_W'(floor_distance) * LIMIT_RAW_W'(steps_per_floor);
  assign stop_count = (limit_raw > LIMIT_RAW_W'(LIMIT_CAP)) ? LIMIT_CAP
                                                           : limit_raw[COUNT_W-1:0];
  // counter at or below the limit means one more step; past it the move ends
  assign steps_left = (step_counter <= stop_count);

  // ---------------------------------------------------------------------------
  // next travel mode
  // ---------------------------------------------------------------------------
  always_comb begin
    travel_mode_next = travel_mode;
    unique case (travel_mode)
      MODE_UP, MODE_DOWN: begin
        if (cancel_request || !steps_left) begin
          travel_mode_next = MODE_IDLE;
        end
      end
      default: begin
        if (start_request) begin
          travel_mode_next = going_up ? MODE_UP : MODE_DOWN;
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // floor, phase, counter and coil updates
  // ---------------------------------------------------------------------------
  always_comb begin
    current_floor_next  = current_floor;
    floor_distance_next = floor_distance;
    phase_index_next    = phase_index;
    step_counter_next   = step_counter;
    held_coils_next     = held_coils;
    if (moving) begin
      // a cancel keeps phase and counter where they are
      if (!cancel_request) begin
        held_coils_next = coil_lookup(phase_index);
        if (steps_left) begin
          step_counter_next = step_counter + COUNT_W'(1);
          phase_index_next  = (travel_mode == MODE_UP) ? phase_index + PHASE_W'(1)
                                                       : phase_index - PHASE_W'(1);
        end else begin
          step_counter_next = '0;
          phase_index_next  = '0;
        end
      end
    end else if (start_request) begin
      // target becomes the current floor at once
      floor_distance_next = going_up ? pressed_button - current_floor
                                     : current_floor - pressed_button;
      current_floor_next  = pressed_button;
    end
  end

  // ---------------------------------------------------------------------------
  // registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      steps_per_floor <= STEPS_RESET;
    end else if (cfg_write) begin
      steps_per_floor <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      travel_mode    <= MODE_IDLE;
      current_floor  <= FLOOR_RESET;
      floor_distance <= '0;
      phase_index    <= '0;
      step_counter   <= '0;
      held_coils     <= '0;
    end else if (item_accept) begin
      travel_mode    <= travel_mode_next;
      current_floor  <= current_floor_next;
      floor_distance <= floor_distance_next;
      phase_index    <= phase_index_next;
      step_counter   <= step_counter_next;
      held_coils     <= held_coils_next;
    end
  end

  // output stage: the new result goes to the result register when it is free or
  // being taken, else it parks in the skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      coil_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        coil_valid <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (item_accept) begin
      if (!coil_valid || out_take) begin
        coil_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      coil_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        coil_pattern <= skid_pattern;
      end
    end else if (item_accept) begin
      if (!coil_valid || out_take) begin
        coil_pattern <= held_coils_next;
      end else begin
        skid_pattern <= held_coils_next;
      end
    end
  end

endmodule
`default_nettype wire

[design/esfc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// esfc_checker
// port-level checks on the elevator stepper controller, bound to the top level
// ----------------------------------------------------------------------------
module esfc_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         button_valid,
  input wire logic                         button_stall,
  input wire logic                         coil_valid,
  input wire logic                         coil_stall,
  input wire logic [esfc_pkg::COIL_W-1:0]  coil_pattern
);
  import esfc_pkg::*;

  // output stage is empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !coil_valid)
    else $error("result valid right after reset");

  // every accepted item leaves a result behind on the next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (rst)
    (button_valid && !button_stall) |=> coil_valid)
    else $error("accepted item produced no result");

  // input only stalls when the result register is occupied
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    button_stall |-> coil_valid)
    else $error("input stalled with an empty result register");

  // coils are off or on one of the half-step patterns
  a_coil_legal: assert property (@(posedge clk) disable iff (rst)
    coil_valid |-> (coil_pattern == 4'h0 || coil_pattern == 4'h1 ||
                    coil_pattern == 4'h3 || coil_pattern == 4'h2 ||
                    coil_pattern == 4'h6 || coil_pattern == 4'h4 ||
                    coil_pattern == 4'hC || coil_pattern == 4'h8 ||
                    coil_pattern == 4'h9))
    else $error("illegal coil pattern");

  // a stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (coil_valid && coil_stall) |=> (coil_valid && $stable(coil_pattern)))
    else $error("stalled result changed");

endmodule

bind elevator_stepper_floor_controller esfc_checker u_esfc_checker (.*);
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives floor-button ticks into the elevator stepper controller and checks
// every coil item against a cycle-free model of the car, under random idling
// on both channels and one long output hold-off
// ----------------------------------------------------------------------------
module tb_top;
  import esfc_pkg::*;

  // no forward progress for this many cycles means the block is hung
  localparam int HANG_LIMIT = 1000;
  // half-step coil patterns for phases 0..7, one nibble per phase
  localparam logic [31:0] HALF_STEPS = 32'h98C46231;
  localparam logic [FLOOR_W-1:0] BAD_BUTTON = FLOOR_W'(7);

  // model of the car: mode, floors, and the motor position
  typedef struct packed {
    travel_mode_t         mode;
    logic [FLOOR_W-1:0]   floor;
    logic [FLOOR_W-1:0]   hops;
    logic [PHASE_W-1:0]   phase;
    logic [COUNT_W-1:0]   count;
    logic [COIL_W-1:0]    held;
  } car_state_t;

  localparam car_state_t CAR_RESET = '{MODE_IDLE, FLOOR_RESET, '0, '0, '0, '0};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [STEPS_W-1:0] cfg_data = STEPS_RESET;
  logic button_valid = 1'b0;
  logic button_stall;
  logic [FLOOR_W-1:0] pressed_button = NO_BUTTON;
  logic coil_valid;
  logic coil_stall = 1'b0;
  logic [COIL_W-1:0] coil_pattern;

  elevator_stepper_floor_controller dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .button_valid   (button_valid),
    .button_stall   (button_stall),
    .pressed_button (pressed_button),
    .coil_valid     (coil_valid),
    .coil_stall     (coil_stall),
    .coil_pattern   (coil_pattern)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // checker side: car state advanced on every accepted tick
  car_state_t          car_now = CAR_RESET;
  logic [STEPS_W-1:0]  car_steps = STEPS_RESET;
  // stimulus side: a second copy, run ahead while the ticks are queued
  car_state_t          plan_car = CAR_RESET;
  logic [STEPS_W-1:0]  plan_steps = STEPS_RESET;

  logic [FLOOR_W-1:0] button_q[$];   // ticks waiting to be driven
  logic [COIL_W-1:0]  coil_q[$];     // coil items still owed by the block

  logic tick_taken = 1'b0;           // input handshake at the last rising edge
  logic steady = 1'b0;               // no idling on either side while set
  int   mismatches = 0;
  int   coils_seen = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  int   quiet_cycles = 0;

  // one motor tick of the car; returns the coil drive seen after the tick
  function automatic logic [COIL_W-1:0] advance_car(inout car_state_t s,
                                                    input logic [FLOOR_W-1:0] btn,
                                                    input logic [STEPS_W-1:0] steps);
    logic [LIMIT_RAW_W-1:0] span;
    logic [COUNT_W-1:0]     stop_at;
    if (s.mode == MODE_UP || s.mode == MODE_DOWN) begin
      if (btn == CANCEL_BUTTON) begin
        // cancel keeps the target floor, phase and counter
        s.mode = MODE_IDLE;
      end else begin
        span = LIMIT_RAW_W'(s.hops) * LIMIT_RAW_W'(steps);
        stop_at = (span > LIMIT_RAW_W'(LIMIT_CAP)) ? LIMIT_CAP : span[COUNT_W-1:0];
        s.held = HALF_STEPS[s.phase*4 +: 4];
        if (s.count <= stop_at) begin
          s.count = s.count + 1'b1;
          s.phase = (s.mode == MODE_UP) ? s.phase + 1'b1 : s.phase - 1'b1;
        end else begin
          s.phase = '0;
          s.count = '0;
          s.mode = MODE_IDLE;
        end
      end
    end else if (btn != NO_BUTTON && btn <= FLOOR_COUNT && btn != s.floor) begin
      if (btn > s.floor) begin
        s.hops = btn - s.floor;
        s.mode = MODE_UP;
      end else begin
        s.hops = s.floor - btn;
        s.mode = MODE_DOWN;
      end
      s.floor = btn;
    end
    return s.held;
  endfunction

  task automatic report_mismatch(input string what, input logic [COIL_W-1:0] got,
                                 input logic [COIL_W-1:0] want);
    $display("mismatch at %0t: %s, coil_pattern got %h want %h", $realtime, what, got,
             want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // monitor: both handshakes at the rising edge; the input side is handled first
  // so an expectation always exists before its coil item could be popped
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      tick_taken <= 1'b0;
      car_now = CAR_RESET;
      car_steps = STEPS_RESET;
    end else begin
      tick_taken <= button_valid && !button_stall;
      if (button_valid && !button_stall)
        coil_q.push_back(advance_car(car_now, pressed_button, car_steps));
      if (coil_valid && !coil_stall) begin
        coils_seen++;
        if (coil_q.size() == 0)
          report_mismatch("coil item with nothing expected", coil_pattern, '0);
        else if (coil_pattern !== coil_q[0])
          report_mismatch("wrong coil drive", coil_pattern, coil_q.pop_front());
        else
          void'(coil_q.pop_front());
      end
    end
  end

  // watchdog: cycles with no item moving on either channel
  always @(posedge clk) begin
    if (rst || (button_valid && !button_stall) || (coil_valid && !coil_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == HANG_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", HANG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // driver: a new tick (or a gap) only once the current one has been taken;
  // the payload holds still while stalled
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      button_valid <= 1'b0;
    end else if (!button_valid || tick_taken) begin
      if (button_q.size() != 0 && (steady || $urandom_range(99) >= 23)) begin
        button_valid <= 1'b1;
        pressed_button <= button_q.pop_front();
      end else begin
        button_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls, plus one long hold-off once traffic is flowing so
  // the output stage fills and the block has to stall its input
  always @(negedge clk) begin
    if (rst) begin
      coil_stall <= 1'b0;
    end else if (hold_left != 0) begin
      coil_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!hold_done && coils_seen >= 50) begin
      hold_done <= 1'b1;
      hold_left <= 40;
      coil_stall <= 1'b1;
    end else begin
      coil_stall <= !steady && ($urandom_range(99) < 23);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_tick(input logic [FLOOR_W-1:0] btn);
    void'(advance_car(plan_car, btn, plan_steps));
    button_q.push_back(btn);
  endtask

  // plain ticks until the planned car stops on its own
  task automatic finish_trip();
    while (plan_car.mode != MODE_IDLE)
      queue_tick(NO_BUTTON);
  endtask

  // wait for the block to drain: nothing queued, nothing offered, nothing owed
  task automatic settle();
    while (button_q.size() != 0 || button_valid || coil_q.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_steps(input logic [STEPS_W-1:0] steps);
    settle();
    cfg_write <= 1'b1;
    cfg_data <= steps;
    car_steps = steps;
    plan_steps = steps;
    plan_car = car_now;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // mostly well-formed trips: press a floor, ride, sometimes cancel or poke
  // other buttons; idle stretches also see no-press, own-floor and bad codes
  task automatic random_ticks(input int n);
    int pick;
    logic [FLOOR_W-1:0] btn;
    repeat (n) begin
      pick = $urandom_range(99);
      if (plan_car.mode == MODE_IDLE) begin
        if (pick < 70) begin
          btn = FLOOR_W'($urandom_range(1, FLOOR_COUNT));
          if (btn == plan_car.floor)
            btn = FLOOR_W'(plan_car.floor % FLOOR_COUNT + 1);
        end else if (pick < 85) begin
          btn = NO_BUTTON;
        end else if (pick < 92) begin
          btn = plan_car.floor;
        end else begin
          btn = BAD_BUTTON;
        end
      end else begin
        if (pick < 90)
          btn = NO_BUTTON;
        else if (pick < 94)
          btn = CANCEL_BUTTON;
        else
          btn = FLOOR_W'($urandom_range(2, 7));
      end
      queue_tick(btn);
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence of phases
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset setting of 4096 steps per floor: idle, bad code, own floor, a long
    // trip up with ignored buttons and a cancel, then down and cancel again
    plan_car = CAR_RESET;
    queue_tick(NO_BUTTON);
    queue_tick(BAD_BUTTON);
    queue_tick(FLOOR_RESET);
    queue_tick(FLOOR_W'(6));
    queue_tick(FLOOR_W'(3));
    queue_tick(NO_BUTTON);
    queue_tick(BAD_BUTTON);
    queue_tick(NO_BUTTON);
    queue_tick(CANCEL_BUTTON);
    queue_tick(NO_BUTTON);
    queue_tick(FLOOR_W'(6));
    queue_tick(FLOOR_W'(2));
    queue_tick(NO_BUTTON);
    queue_tick(FLOOR_W'(4));
    queue_tick(NO_BUTTON);
    queue_tick(CANCEL_BUTTON);

    // zero steps per floor: the counter left over from the cancel already
    // exceeds the limit, so the next trip drives one pattern and stops;
    // a trip from a cleared counter is a single step
    set_steps('0);
    queue_tick(FLOOR_W'(5));
    queue_tick(NO_BUTTON);
    queue_tick(NO_BUTTON);
    queue_tick(FLOOR_W'(4));
    queue_tick(NO_BUTTON);
    queue_tick(NO_BUTTON);
    queue_tick(NO_BUTTON);
    random_ticks(60);

    // one step per floor with both sides running flat out
    set_steps(STEPS_W'(1));
    steady = 1'b1;
    random_ticks(100);
    settle();
    steady = 1'b0;

    // a small random setting, then park the car at the ground floor
    set_steps(STEPS_W'($urandom_range(2, 8)));
    random_ticks(150);
    finish_trip();
    if (plan_car.floor != FLOOR_RESET) begin
      queue_tick(FLOOR_RESET);
      finish_trip();
    end

    // five-floor trip with a setting just past the cap: the step limit saturates
    // instead of wrapping to a handful of steps, so the car still moves until
    // the cancel
    set_steps(STEPS_W'(13108));
    queue_tick(FLOOR_W'(6));
    repeat (12) queue_tick(NO_BUTTON);
    queue_tick(CANCEL_BUTTON);
    queue_tick(NO_BUTTON);

    // a setting of 8192 steps per floor: trips are long, so cancels end most of them
    set_steps(STEPS_W'(8192));
    queue_tick(FLOOR_W'(3));
    repeat (20) queue_tick(NO_BUTTON);
    queue_tick(CANCEL_BUTTON);
    random_ticks(60);

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
